// ===== src/tgc_pkg.sv =====
// Package: shared types, constants and helpers for the touch gesture classifier.
`timescale 1ns / 1ps
`default_nettype none
package tgc_pkg;

  // Field widths fixed by the interface
  localparam int FIELD_W = 16;
  localparam int TIME_W  = 32;
  localparam int TAP_W   = 16;
  localparam int LPT_W   = 32;

  // Coordinate bits actually used; the rest of each 16-bit field is ignored
  localparam int COORD_WIDTH = 16;
  localparam int DIFF_W      = COORD_WIDTH + 1;
  localparam int CMP_W       = (DIFF_W > TAP_W) ? DIFF_W : TAP_W;

  // Register reset values
  localparam logic [TAP_W-1:0] TAP_DISTANCE_RESET = TAP_W'(12);
  localparam logic [LPT_W-1:0] LONG_PRESS_RESET   = LPT_W'(600);

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_DISTANCE = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS   = CFG_IDX_W'(1);

  // Depth of the queue between classifier and emitter
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic signed [COORD_WIDTH-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]      diff_t;

  typedef enum logic [2:0] {
    EV_DOWN = 3'd0,
    EV_MOVE = 3'd1,
    EV_UP   = 3'd2,
    EV_TAP  = 3'd3,
    EV_LONG = 3'd4
  } kind_t;

  typedef struct packed {
    logic                     touch_pressed;
    logic signed [FIELD_W-1:0] touch_x;
    logic signed [FIELD_W-1:0] touch_y;
    logic [TIME_W-1:0]         sample_time;
  } sample_t;

  typedef struct packed {
    kind_t                     event_kind;
    logic signed [FIELD_W-1:0] event_x;
    logic signed [FIELD_W-1:0] event_y;
    logic signed [FIELD_W-1:0] delta_x;
    logic signed [FIELD_W-1:0] delta_y;
    logic [TIME_W-1:0]         event_time;
    logic                      last_of_run;
  } event_t;

  // One classified request: first event, plus a flag for a tap that may follow it
  typedef struct packed {
    kind_t                     kind;
    logic                      tap;
    logic signed [FIELD_W-1:0] x;
    logic signed [FIELD_W-1:0] y;
    logic signed [FIELD_W-1:0] dx;
    logic signed [FIELD_W-1:0] dy;
    logic [TIME_W-1:0]         t;
  } job_t;

  // Low coordinate bits of a field, read as two's complement
  function automatic coord_t coord_of(input logic signed [FIELD_W-1:0] v);
    return coord_t'(v[COORD_WIDTH-1:0]);
  endfunction

  // Sign-extend a coordinate to the output field width
  function automatic logic signed [FIELD_W-1:0] sext_out(input coord_t v);
    return FIELD_W'(v);
  endfunction

  // Exact difference of two coordinates
  function automatic diff_t coord_diff(input coord_t a, input coord_t b);
    return DIFF_W'(a) - DIFF_W'(b);
  endfunction

  // Difference wrapped to the coordinate width, sign-extended for output
  function automatic logic signed [FIELD_W-1:0] wrap_out(input diff_t d);
    coord_t w;
    w = coord_t'(d[COORD_WIDTH-1:0]);
    return FIELD_W'(w);
  endfunction

  // |d| <= lim
  function automatic logic in_box(input diff_t d, input logic [TAP_W-1:0] lim);
    logic [DIFF_W-1:0] mag;
    mag = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    return CMP_W'(mag) <= CMP_W'(lim);
  endfunction

endpackage
`default_nettype wire

// ===== src/tgc_front.sv =====
// Front end: holds touch state and config, classifies each sample into a request.
`timescale 1ns / 1ps
`default_nettype none
module tgc_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              sample_valid,
  output logic                                   sample_ready,
  input  wire tgc_pkg::sample_t                  sample,
  input  wire logic                              cfg_we,
  input  wire logic [tgc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [tgc_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  wire logic                              q_full,
  output logic                                   q_push,
  output tgc_pkg::job_t                          q_job
);
  import tgc_pkg::*;

  // Configuration registers
  logic [TAP_W-1:0] tap_distance;
  logic [LPT_W-1:0] long_press_time;

  // Touch state
  logic              prev_pressed;
  coord_t            prev_x;
  coord_t            prev_y;
  coord_t            down_x;
  coord_t            down_y;
  logic [TIME_W-1:0] down_time;
  logic              long_press_done;

  coord_t            cur_x;
  coord_t            cur_y;
  diff_t             move_dx;
  diff_t             move_dy;
  diff_t             down_dx;
  diff_t             down_dy;
  logic              still;
  logic              due;
  logic [TIME_W-1:0] elapsed;
  logic              is_down;
  logic              is_move;
  logic              is_up;
  logic              is_long;
  logic              has_event;
  logic              accept;

  assign sample_ready = !q_full;
  assign accept       = sample_valid && sample_ready;

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_distance    <= TAP_DISTANCE_RESET;
      long_press_time <= LONG_PRESS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TAP_DISTANCE: tap_distance    <= cfg_data[TAP_W-1:0];
        CFG_LONG_PRESS:   long_press_time <= cfg_data[LPT_W-1:0];
        default:          ;
      endcase
    end
  end

  // Offsets and tests
  always_comb begin
    cur_x   = coord_of(sample.touch_x);
    cur_y   = coord_of(sample.touch_y);
    move_dx = coord_diff(cur_x, prev_x);
    move_dy = coord_diff(cur_y, prev_y);
    down_dx = coord_diff(cur_x, down_x);
    down_dy = coord_diff(cur_y, down_y);
    still   = in_box(down_dx, tap_distance) && in_box(down_dy, tap_distance);
    elapsed = sample.sample_time - down_time;
    due     = elapsed >= long_press_time;
  end

  // Classification, first match wins
  always_comb begin
    is_down = 1'b0;
    is_move = 1'b0;
    is_up   = 1'b0;
    is_long = 1'b0;
    priority if (sample.touch_pressed && !prev_pressed) begin
      is_down = 1'b1;
    end else if (sample.touch_pressed && (cur_x != prev_x || cur_y != prev_y)) begin
      is_move = 1'b1;
    end else if (!sample.touch_pressed && prev_pressed) begin
      is_up = 1'b1;
    end else if (sample.touch_pressed && !long_press_done) begin
      is_long = still && due;
    end else begin
      is_long = 1'b0;
    end
    has_event = is_down || is_move || is_up || is_long;
  end

  // Request for the emitter
  always_comb begin
    q_job.x   = sext_out(cur_x);
    q_job.y   = sext_out(cur_y);
    q_job.t   = sample.sample_time;
    q_job.tap = is_up && !long_press_done && still;
    q_job.dx  = wrap_out(down_dx);
    q_job.dy  = wrap_out(down_dy);
    priority if (is_down) begin
      q_job.kind = EV_DOWN;
      q_job.dx   = '0;
      q_job.dy   = '0;
    end else if (is_move) begin
      q_job.kind = EV_MOVE;
      q_job.dx   = wrap_out(move_dx);
      q_job.dy   = wrap_out(move_dy);
    end else if (is_up) begin
      q_job.kind = EV_UP;
    end else begin
      q_job.kind = EV_LONG;
    end
    q_push = accept && has_event;
  end

  // State update per accepted sample
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_pressed    <= 1'b0;
      prev_x          <= '0;
      prev_y          <= '0;
      down_x          <= '0;
      down_y          <= '0;
      down_time       <= '0;
      long_press_done <= 1'b0;
    end else if (accept) begin
      prev_pressed <= sample.touch_pressed;
      prev_x       <= cur_x;
      prev_y       <= cur_y;
      if (is_down) begin
        down_x          <= cur_x;
        down_y          <= cur_y;
        down_time       <= sample.sample_time;
        long_press_done <= 1'b0;
      end else if (is_long) begin
        long_press_done <= 1'b1;
      end
    end
  end

  // A second long press within one press is a bug
  a_long_once: assert property (@(posedge clk) disable iff (rst)
    q_push && long_press_done |-> q_job.kind != EV_LONG)
    else $error("long press requested twice in one press");

  // Tap follows only an up request
  a_tap_only_up: assert property (@(posedge clk) disable iff (rst)
    q_push && q_job.tap |-> q_job.kind == EV_UP)
    else $error("tap attached to a non-up request");

endmodule
`default_nettype wire

// ===== src/tgc_queue.sv =====
// Short request queue between classifier and emitter.
`timescale 1ns / 1ps
`default_nettype none
module tgc_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire tgc_pkg::job_t push_job,
  output logic               full,
  output logic               head_valid,
  output tgc_pkg::job_t      head_job,
  input  wire logic          pop
);
  import tgc_pkg::*;

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = count == QCNT_W'(QUEUE_DEPTH);
  assign head_valid = count != '0;
  assign head_job   = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full && !pop))
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== src/tgc_back.sv =====
// Back end: expands queued requests into events through an output register.
`timescale 1ns / 1ps
`default_nettype none
module tgc_back (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          head_valid,
  input  wire tgc_pkg::job_t head_job,
  output logic               pop,
  output logic               result_valid,
  input  wire logic          result_ready,
  output tgc_pkg::event_t    result
);
  import tgc_pkg::*;

  logic   tap_phase;
  logic   load;
  logic   first_of_two;
  event_t ev_next;

  // Output register may take a new event when empty or being drained
  assign load         = !result_valid || result_ready;
  assign first_of_two = head_job.tap && !tap_phase;
  assign pop          = load && head_valid && !first_of_two;

  // Event built from the queue head
  always_comb begin
    ev_next.event_kind  = tap_phase ? EV_TAP : head_job.kind;
    ev_next.event_x     = head_job.x;
    ev_next.event_y     = head_job.y;
    ev_next.delta_x     = head_job.dx;
    ev_next.delta_y     = head_job.dy;
    ev_next.event_time  = head_job.t;
    ev_next.last_of_run = !first_of_two;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      tap_phase    <= 1'b0;
    end else if (load) begin
      result_valid <= head_valid;
      if (head_valid) begin
        tap_phase <= first_of_two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && head_valid) begin
      result <= ev_next;
    end
  end

  a_phase_head: assert property (@(posedge clk) disable iff (rst)
    tap_phase |-> head_valid && head_job.tap)
    else $error("tap pending without an up request at head");

  // A freshly loaded tap sits right behind its up event
  a_up_before_tap: assert property (@(posedge clk) disable iff (rst)
    $rose(result_valid && result.event_kind == EV_TAP) |->
      $past(result.event_kind) == EV_UP && !$past(result.last_of_run))
    else $error("tap not preceded by its up event");

endmodule
`default_nettype wire

// ===== src/touch_gesture_classifier.sv =====
// Top level: touch gesture classifier, classifier front end, queue, event emitter.
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+------------------------
//  sample    | in        | sample_valid/sample_ready  | tgc_pkg::sample_t
//  result    | out       | result_valid/result_ready  | tgc_pkg::event_t
//  cfg       | in        | cfg_we (no wait)           | cfg_index, cfg_data
//
// A sample request is taken every cycle while the two-entry queue has room; its
// events leave one per cycle from the output register while result_ready is high.
// An up followed by a tap yields two events from one request; every other sample
// yields one event or none.
// Reset (rst, synchronous) restores register defaults and clears the touch state.
// The queue absorbs a stalled result port until it fills; then sample_ready drops.
`timescale 1ns / 1ps
`default_nettype none
module touch_gesture_classifier (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           sample_valid,
  output logic                                sample_ready,
  input  wire tgc_pkg::sample_t               sample,
  output logic                                result_valid,
  input  wire logic                           result_ready,
  output tgc_pkg::event_t                     result,
  input  wire logic                           cfg_we,
  input  wire logic [tgc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tgc_pkg::CFG_DATA_W-1:0] cfg_data
);
  import tgc_pkg::*;

  logic q_full;
  logic q_push;
  job_t q_job;
  logic head_valid;
  job_t head_job;
  logic q_pop;

  tgc_front u_front (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_job        (q_job)
  );

  tgc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_job),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (q_pop)
  );

  tgc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_job     (head_job),
    .pop          (q_pop),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
`default_nettype wire

// ===== sim/testbench.sv =====
// Testbench for the touch gesture classifier: queued touch samples, predicted event checks.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import tgc_pkg::*;

  localparam int PHASE_ITEMS  = 200;
  localparam int RAND_PHASES  = 6;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 400;
  localparam int CYCLE_LIMIT  = 200000;

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  sample_valid = 1'b0;
  logic                  sample_ready;
  sample_t               sample       = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  event_t                result;
  logic                  cfg_we       = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index    = '0;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  // Stimulus queue and pacing knobs
  sample_t          samples_to_send[$];
  int               send_idle_pct = 0;
  int               recv_idle_pct = 0;
  logic             hold_arm      = 1'b0;
  logic             hold_used     = 1'b0;
  int               hold_left     = 0;
  int               cycle_count   = 0;
  int               mismatches    = 0;
  logic [TIME_W-1:0] stamp        = '0;
  logic [TAP_W-1:0] tap_now       = TAP_DISTANCE_RESET;
  logic [LPT_W-1:0] lp_now        = LONG_PRESS_RESET;

  // Gesture tracker copy: registers and touch state
  logic [TAP_W-1:0]  tap_cfg     = TAP_DISTANCE_RESET;
  logic [LPT_W-1:0]  hold_cfg    = LONG_PRESS_RESET;
  logic              was_pressed = 1'b0;
  int                last_x      = 0;
  int                last_y      = 0;
  int                anchor_x    = 0;
  int                anchor_y    = 0;
  logic [TIME_W-1:0] anchor_time = '0;
  logic              long_sent   = 1'b0;
  event_t            expected_events[$];
  event_t            want;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  touch_gesture_classifier DUT (
    .clk, .rst,
    .sample_valid, .sample_ready, .sample,
    .result_valid, .result_ready, .result,
    .cfg_we, .cfg_index, .cfg_data
  );

  // Low COORD_WIDTH bits of a field, read as two's complement
  function automatic int coord_value(logic [FIELD_W-1:0] v);
    int r;
    r = int'(v) & ((1 << COORD_WIDTH) - 1);
    if (r >= (1 << (COORD_WIDTH - 1))) r -= (1 << COORD_WIDTH);
    return r;
  endfunction

  // Delta wrapped to the coordinate width, sign-extended to the field
  function automatic logic signed [FIELD_W-1:0] wrapped(int d);
    return FIELD_W'(coord_value(d[FIELD_W-1:0]));
  endfunction

  // Exact offset from the down point inside the tap box
  function automatic logic near_anchor(int dx, int dy);
    return (dx < 0 ? -dx : dx) <= int'(tap_cfg) && (dy < 0 ? -dy : dy) <= int'(tap_cfg);
  endfunction

  function automatic void add_event(kind_t k, int x, int y, logic signed [FIELD_W-1:0] dx,
                                    logic signed [FIELD_W-1:0] dy, logic [TIME_W-1:0] t,
                                    logic last);
    event_t e;
    e.event_kind  = k;
    e.event_x     = FIELD_W'(x);
    e.event_y     = FIELD_W'(y);
    e.delta_x     = dx;
    e.delta_y     = dy;
    e.event_time  = t;
    e.last_of_run = last;
    expected_events.push_back(e);
  endfunction

  // Classify one touch sample into zero, one or two gesture events
  function automatic void classify_sample(sample_t s);
    int   x, y, dx, dy;
    logic tap;
    x = coord_value(s.touch_x);
    y = coord_value(s.touch_y);
    if (s.touch_pressed && !was_pressed) begin
      anchor_x    = x;
      anchor_y    = y;
      anchor_time = s.sample_time;
      long_sent   = 1'b0;
      add_event(EV_DOWN, x, y, '0, '0, s.sample_time, 1'b1);
    end else if (s.touch_pressed && (x != last_x || y != last_y)) begin
      add_event(EV_MOVE, x, y, wrapped(x - last_x), wrapped(y - last_y), s.sample_time, 1'b1);
    end else if (!s.touch_pressed && was_pressed) begin
      dx  = x - anchor_x;
      dy  = y - anchor_y;
      tap = !long_sent && near_anchor(dx, dy);
      add_event(EV_UP, x, y, wrapped(dx), wrapped(dy), s.sample_time, !tap);
      if (tap) add_event(EV_TAP, x, y, wrapped(dx), wrapped(dy), s.sample_time, 1'b1);
    end else if (s.touch_pressed && !long_sent) begin
      dx = x - anchor_x;
      dy = y - anchor_y;
      if (near_anchor(dx, dy) && (s.sample_time - anchor_time) >= hold_cfg) begin
        add_event(EV_LONG, x, y, wrapped(dx), wrapped(dy), s.sample_time, 1'b1);
        long_sent = 1'b1;
      end
    end
    was_pressed = s.touch_pressed;
    last_x      = x;
    last_y      = y;
  endfunction

  // Sample driver: tracks register writes, predicts on each accepted request
  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_TAP_DISTANCE) tap_cfg = cfg_data[TAP_W-1:0];
        else if (cfg_index == CFG_LONG_PRESS) hold_cfg = cfg_data[LPT_W-1:0];
      end
      if (sample_valid && sample_ready) classify_sample(sample);
      if (!sample_valid || sample_ready) begin
        if (samples_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          sample       <= samples_to_send.pop_front();
          sample_valid <= 1'b1;
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %h, got %h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Event monitor: compares each accepted event with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        if (expected_events.size() == 0) begin
          $display("%0t: unexpected event, expected none, got %h", $time, result);
          mismatches++;
        end else begin
          want = expected_events.pop_front();
          check_field("event_kind", want.event_kind, result.event_kind);
          check_field("event_x", want.event_x, result.event_x);
          check_field("event_y", want.event_y, result.event_y);
          check_field("delta_x", want.delta_x, result.delta_x);
          check_field("delta_y", want.delta_y, result.delta_y);
          check_field("event_time", want.event_time, result.event_time);
          check_field("last_of_run", want.last_of_run, result.last_of_run);
        end
      end
      result_ready <= (hold_left == 0) && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // One long receiver hold-off so the queue fills and the input stalls
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (hold_arm && !hold_used) begin
      hold_left <= LONG_HOLD;
      hold_used <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  task automatic put(logic pressed, int x, int y, logic [TIME_W-1:0] t);
    sample_t s;
    s.touch_pressed = pressed;
    s.touch_x       = FIELD_W'(x);
    s.touch_y       = FIELD_W'(y);
    s.sample_time   = t;
    samples_to_send.push_back(s);
  endtask

  // Wait for no request in flight and no event outstanding, then let the pipe settle
  task automatic wait_idle();
    while (samples_to_send.size() != 0 || sample_valid || expected_events.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_regs(logic [TAP_W-1:0] tap, logic [LPT_W-1:0] hold);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_TAP_DISTANCE;
    cfg_data  <= CFG_DATA_W'(tap);
    @(posedge clk);
    cfg_index <= CFG_LONG_PRESS;
    cfg_data  <= CFG_DATA_W'(hold);
    @(posedge clk);
    cfg_we  <= 1'b0;
    tap_now = tap;
    lp_now  = hold;
    @(negedge clk);
  endtask

  function automatic int pick_coord();
    case ($urandom_range(3))
      0: return $urandom_range(1) ? 32767 : -32768;
      1: return int'($urandom_range(0, 40)) - 20;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // Offset that lands inside the tap box or just past its edge
  function automatic int tap_offset();
    int o;
    o = $urandom_range(0, int'(tap_now) + 1);
    return $urandom_range(1) ? o : -o;
  endfunction

  task automatic step_time(logic [TIME_W-1:0] down_at);
    case ($urandom_range(4))
      0: stamp = stamp + $urandom_range(0, 40);
      1: stamp = down_at + lp_now;
      2: stamp = down_at + lp_now - 1;
      3: stamp = stamp + $urandom;
      default: stamp = stamp + (lp_now >> 1);
    endcase
  endtask

  // Mostly press / hold / release gestures with random content, some noise
  task automatic queue_gestures(int items);
    int                added, steps, base_x, base_y, px, py;
    logic [TIME_W-1:0] down_at;
    added = 0;
    while (added < items) begin
      if ($urandom_range(99) < 15) begin
        put(1'($urandom_range(1)), $urandom, $urandom, $urandom);
        added++;
      end else begin
        base_x  = pick_coord();
        base_y  = pick_coord();
        stamp   = stamp + $urandom_range(1, 30);
        down_at = stamp;
        put(1'b1, base_x, base_y, stamp);
        added++;
        px    = base_x;
        py    = base_y;
        steps = $urandom_range(0, 6);
        for (int i = 0; i < steps; i++) begin
          case ($urandom_range(3))
            0: ;  // hold still
            1: begin
              px = base_x + tap_offset();
              py = base_y + tap_offset();
            end
            2: begin
              px = $urandom_range(0, 65535);
              py = $urandom_range(0, 65535);
            end
            default: begin
              px = px + int'($urandom_range(0, 2)) - 1;
              py = py + int'($urandom_range(0, 2)) - 1;
            end
          endcase
          step_time(down_at);
          put(1'b1, px, py, stamp);
          added++;
        end
        // release: in place, near the down point, or far away
        case ($urandom_range(2))
          0: ;
          1: begin
            px = base_x + tap_offset();
            py = base_y + tap_offset();
          end
          default: begin
            px = pick_coord();
            py = pick_coord();
          end
        endcase
        stamp = stamp + $urandom_range(1, 40);
        put(1'b0, px, py, stamp);
        added++;
        if ($urandom_range(4) == 0) begin
          stamp = stamp + $urandom_range(1, 40);
          put(1'b0, $urandom, $urandom, stamp);
          added++;
        end
      end
    end
  endtask

  initial begin
    logic [TAP_W-1:0] tap_pick;
    logic [LPT_W-1:0] hold_pick;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed, reset settings: extremes, long press, wrapped deltas and time
    send_idle_pct = 23;
    recv_idle_pct = 67;
    put(1'b0, 0, 0, 32'd10);                 // released while released
    put(1'b1, 32767, -32768, 32'd20);        // down at the corner
    put(1'b1, 32767, -32768, 32'd620);       // still, long press exactly due
    put(1'b1, -32768, 32767, 32'd2010);      // move with wrapped deltas
    put(1'b0, -32768, 32767, 32'd2020);      // up after long press, no tap
    put(1'b1, 100, 100, 32'hFFFF_FFF0);
    put(1'b1, 105, 95, 32'hFFFF_FFF8);
    put(1'b1, 105, 95, 32'h0000_0250);       // elapsed across time wrap
    put(1'b0, 112, 88, 32'h0000_0260);
    put(1'b1, -5, -5, 32'h0000_0300);
    put(1'b0, 7, 7, 32'h0000_0310);          // up plus tap at box edge
    put(1'b1, 0, 0, 32'h0000_0320);
    put(1'b0, 13, 0, 32'h0000_0330);         // just outside the box
    put(1'b1, 1, 1, 32'h0000_0400);
    put(1'b1, 1, 14, 32'h0000_0410);
    put(1'b1, 1, 14, 32'h0000_1000);         // still but outside the box
    put(1'b0, 1, 1, 32'h0000_1010);
    wait_idle();

    // Zero tap distance and zero long-press time
    set_regs('0, '0);
    put(1'b1, 3, 4, 32'd50);
    put(1'b1, 3, 4, 32'd50);
    put(1'b0, 3, 4, 32'd51);
    put(1'b1, 3, 4, 32'd52);
    put(1'b0, 3, 4, 32'd53);
    wait_idle();

    // Largest settings
    set_regs(16'hFFFF, 32'hFFFF_FFFF);
    put(1'b1, 32767, -32768, 32'd5);
    put(1'b1, 32767, -32768, 32'd4);         // elapsed wraps to the maximum
    put(1'b0, 32767, -32768, 32'd6);
    put(1'b1, 32767, 0, 32'd7);
    put(1'b0, -32768, 0, 32'd8);             // exact offset at the largest box
    stamp = 32'd100;

    // Random phases over several settings and pacing modes
    for (int p = 0; p < RAND_PHASES; p++) begin
      wait_idle();
      case ($urandom_range(3))
        0: tap_pick = 16'd1;
        1: tap_pick = 16'hFFFF;
        2: tap_pick = TAP_W'($urandom_range(1, 40));
        default: tap_pick = TAP_W'($urandom_range(1, 65535));
      endcase
      case ($urandom_range(4))
        0: hold_pick = 32'd1;
        1: hold_pick = $urandom_range(1, 200);
        2: hold_pick = 32'd600;
        3: hold_pick = $urandom_range(1, 32'hFFFF_FFFF);
        default: hold_pick = 32'hFFFF_FFFF;
      endcase
      if (p == 0) begin
        tap_pick  = 16'd1;
        hold_pick = 32'd1;
      end
      set_regs(tap_pick, hold_pick);
      if (p < 2) begin
        send_idle_pct = 23;
        recv_idle_pct = 67;
      end else if (p < 4) begin
        send_idle_pct = 67;
        recv_idle_pct = 23;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      queue_gestures(PHASE_ITEMS);
      if (p == RAND_PHASES - 1) hold_arm = 1'b1;
    end

    wait_idle();
    if (mismatches == 0) $display("testbench: clean");
    else $display("testbench: errors");
    $finish;
  end

endmodule
`default_nettype wire
